// ===== rtl/rpn_pkg.sv =====
// Shared types and constants for the RPN stack evaluator.
// No dependencies; every other rtl file imports this package.
package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);
  // command queue depth, power of two
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BAD   = 3'd1,
    ST_FEW   = 3'd2,
    ST_DIV0  = 3'd3,
    ST_COUNT = 3'd4,
    ST_OVER  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // one classified request from front to back
  typedef struct packed {
    op_t        kind;
    logic [3:0] digit;
    logic       last;
    logic       bad;   // final bad-input verdict, meaningful with last
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

// ===== rtl/rpn_front.sv =====
// Front end: accepts characters, tracks token syntax, classifies requests.
// Depends on rpn_pkg.
module rpn_front import rpn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       no_char,
  input  logic       last,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  logic prev_digit, bad_seen, any_seen;
  logic prev_digit_next, bad_next, any_next;
  logic is_digit, is_op, accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_digit = char_code inside {[CH_ZERO:CH_NINE]};
    is_op    = char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    prev_digit_next = prev_digit;
    bad_next        = bad_seen;
    any_next        = any_seen;
    q_data.kind  = OP_NONE;
    q_data.digit = 4'(char_code - CH_ZERO);
    q_data.last  = last;
    if (!no_char) begin
      any_next        = 1'b1;
      prev_digit_next = is_digit;
      if (!is_digit && !is_op && char_code != CH_SPACE) bad_next = 1'b1;
      if (prev_digit && char_code != CH_SPACE) bad_next = 1'b1;
      if (is_digit) q_data.kind = OP_DIGIT;
      else begin
        case (char_code)
          CH_PLUS:  q_data.kind = OP_ADD;
          CH_MINUS: q_data.kind = OP_SUB;
          CH_STAR:  q_data.kind = OP_MUL;
          CH_SLASH: q_data.kind = OP_DIV;
          default:  q_data.kind = OP_NONE;
        endcase
      end
    end
    q_data.bad = bad_next || !any_next;
    // separators and bad characters leave the stack alone
    q_push = accept && (q_data.kind != OP_NONE || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_digit <= 1'b0;
      bad_seen   <= 1'b0;
      any_seen   <= 1'b0;
    end else if (accept) begin
      if (last) begin
        prev_digit <= 1'b0;
        bad_seen   <= 1'b0;
        any_seen   <= 1'b0;
      end else begin
        prev_digit <= prev_digit_next;
        bad_seen   <= bad_next;
        any_seen   <= any_next;
      end
    end
  end

endmodule

// ===== rtl/rpn_queue.sv =====
// Small FIFO of classified requests between front and back.
// Depends on rpn_pkg.
module rpn_queue import rpn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full     = (fill == QCNT_W'(Q_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/rpn_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_divider import rpn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  logic [VALUE_WIDTH-1:0] rem, quo, dvs;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   busy, neg;
  logic [VALUE_WIDTH:0]   shifted, diff;

  assign shifted  = {rem, quo[VALUE_WIDTH-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = neg ? -quo : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[VALUE_WIDTH-1] ? -dividend : dividend;
      dvs <= divisor[VALUE_WIDTH-1] ? -divisor : divisor;
      neg <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
    end else if (busy) begin
      if (!diff[VALUE_WIDTH]) begin
        rem <= diff[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rpn_back.sv =====
// Back end: operand stack, arithmetic, error tracking and the result register.
// Depends on rpn_pkg and rpn_divider.
module rpn_back import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [2:0]  status
);

  // top of stack lives in tos; mem holds the entries below it
  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] tos, rd_data, arith;
  logic [CNT_W-1:0]       count, cm1, cm2;
  status_t                err, fin_status;
  cmd_t                   cur;
  back_state_t            state, state_next;

  logic do_push, do_over, do_few, do_arith, do_div0, do_divres, do_fin;
  logic mem_we, rd_en, div_start, div_done;
  logic [VALUE_WIDTH-1:0] div_q;

  assign cm1 = count - CNT_W'(1);
  assign cm2 = count - CNT_W'(2);

  rpn_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (tos),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (cur.kind)
      OP_ADD:  arith = rd_data + tos;
      OP_SUB:  arith = rd_data - tos;
      default: arith = rd_data * tos;
    endcase
    if (cur.bad)                fin_status = ST_BAD;
    else if (err != ST_OK)      fin_status = err;
    else if (count != CNT_W'(1)) fin_status = ST_COUNT;
    else                        fin_status = ST_OK;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    do_push    = 1'b0;
    do_over    = 1'b0;
    do_few     = 1'b0;
    do_arith   = 1'b0;
    do_div0    = 1'b0;
    do_divres  = 1'b0;
    do_fin     = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_data.last ? B_FIN : B_IDLE;
          if (err == ST_OK) begin
            if (q_data.kind == OP_DIGIT) begin
              if (count == CNT_W'(STACK_DEPTH)) do_over = 1'b1;
              else begin
                do_push = 1'b1;
                mem_we  = (count != '0);
              end
            end else if (q_data.kind != OP_NONE) begin
              if (count < CNT_W'(2)) do_few = 1'b1;
              else begin
                rd_en      = 1'b1;
                state_next = B_EXEC;
              end
            end
          end
        end
      end
      B_EXEC: begin
        state_next = cur.last ? B_FIN : B_IDLE;
        if (cur.kind == OP_DIV) begin
          if (tos == '0) do_div0 = 1'b1;
          else begin
            div_start  = 1'b1;
            state_next = B_DIV;
          end
        end else do_arith = 1'b1;
      end
      B_DIV: begin
        if (div_done) begin
          do_divres  = 1'b1;
          state_next = cur.last ? B_FIN : B_IDLE;
        end
      end
      B_FIN: begin
        if (!out_valid || out_ready) begin
          do_fin     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[cm1[PTR_W-1:0]] <= tos;
    if (rd_en)  rd_data <= mem[cm2[PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (do_push)   tos <= VALUE_WIDTH'(q_data.digit);
    if (do_arith)  tos <= arith;
    if (do_divres) tos <= div_q;
    if (do_fin) begin
      status <= fin_status;
      value  <= (fin_status == ST_OK) ? 32'($signed(tos)) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (do_push)             count <= count + CNT_W'(1);
      if (do_arith || do_divres) count <= cm1;
      if (do_over) err <= ST_OVER;
      if (do_few)  err <= ST_FEW;
      if (do_div0) err <= ST_DIV0;
      if (do_fin) begin
        out_valid <= 1'b1;
        count     <= '0;
        err       <= ST_OK;
      end
    end
  end

endmodule

// ===== rtl/rpn_stack_evaluator.sv =====
// Top level of the RPN stack evaluator: front end, request queue, back end.
// Depends on rpn_pkg, rpn_front, rpn_queue, rpn_back (and rpn_divider below it).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | to block  | in_valid / in_ready  | char_code[7:0], no_char, last
//   out     | from block| out_valid / out_ready| value[31:0] signed, status[2:0]
//
// The front end takes one character per cycle while the 4-entry request
// queue has room; spaces and bad characters enter the queue only with last.
// Back end per request: a digit is pushed as it is popped; + - * pass
// through B_EXEC for the registered stack read; / also waits in B_DIV for
// the bit-serial divider; a last request adds B_FIN to load the result register.
// Reset (rst, synchronous) clears counts, flags, queue and handshakes; the
// stack memory is not cleared, only entries below the count are read.
// A stalled result holds in the output register; the back end keeps
// working and blocks only when a second result is ready before the first
// has been taken.

module rpn_stack_evaluator import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        no_char,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [2:0]  status
);

  cmd_t push_data, pop_data;
  logic q_push, q_full, q_pop, q_empty;

  // classify characters and track token syntax
  rpn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .no_char   (no_char),
    .last      (last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  // decouples front end from slow operations such as divide
  rpn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // stack, arithmetic, errors and result register
  rpn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

endmodule

// ===== rtl/rpn_checker.sv =====
// Port-level checks for the RPN stack evaluator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_evaluator.
module rpn_checker import rpn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic [2:0]  status
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == 32'd0)
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVER)
    else $error("status code out of range");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind rpn_stack_evaluator rpn_checker u_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for rpn_stack_evaluator: directed and random expressions.
// Depends on rpn_pkg (character codes, status_t) and the rpn_stack_evaluator RTL.
module testbench;
  import rpn_pkg::*;

  // Cycles without any request or result moving before the run is declared hung.
  // The slowest legal stretch is four queued divisions plus a stalled result,
  // so this leaves a wide margin.
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  // one item of an expression: character plus its no_char flag
  typedef struct packed {
    logic [7:0] c;
    logic       blank;
  } sym_t;

  typedef struct packed {
    logic [31:0] val;
    status_t     st;
  } outcome_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_JOINED,     // digit run straight into the next character
    FLAW_UNDERFLOW,  // operator before any operand
    FLAW_LEFTOVER,   // one operand too many at the end
    FLAW_NOISE,      // one random byte dropped in
    FLAW_JUNK        // nothing but random bytes
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = '0;
  logic        no_char = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic [2:0]  status;

  // Predictor state: a private copy of the operand stack and expression flags.
  logic [31:0] stack_mem [STACK_DEPTH];
  int          live_count = 0;
  bit          prev_digit = 1'b0;
  bit          bad_seen = 1'b0;
  bit          any_seen = 1'b0;
  status_t     first_err = ST_OK;

  outcome_t    pending_outcomes[$];
  outcome_t    want;
  int          mismatches = 0;
  int          items_sent = 0;
  int          stall_cycles = 0;
  bit          steady = 1'b0;  // 1: neither side idles

  rpn_stack_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .no_char   (no_char),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Signed division truncating toward zero, done on magnitudes so that the
  // most negative value over minus one wraps back to itself.
  function automatic logic [31:0] quotient_toward_zero(input logic [31:0] num,
                                                       input logic [31:0] den);
    logic [31:0] mag_n, mag_d, q;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    q = mag_n / mag_d;
    return (num[31] ^ den[31]) ? -q : q;
  endfunction

  function automatic void evaluate_char(input logic [7:0] c);
    logic        is_digit, is_op;
    logic [31:0] lhs, rhs, res;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_op = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    any_seen = 1'b1;
    if (!is_digit && !is_op && c != CH_SPACE) bad_seen = 1'b1;
    // a digit must be followed by a space
    if (prev_digit && c != CH_SPACE) bad_seen = 1'b1;
    prev_digit = is_digit;
    // after the first evaluation error the stack is frozen
    if (first_err == ST_OK) begin
      if (is_digit) begin
        if (live_count >= STACK_DEPTH) begin
          first_err = ST_OVER;
        end else begin
          stack_mem[live_count] = 32'(c - CH_ZERO);
          live_count++;
        end
      end else if (is_op) begin
        if (live_count < 2) begin
          first_err = ST_FEW;
        end else begin
          rhs = stack_mem[live_count - 1];
          lhs = stack_mem[live_count - 2];
          if (c == CH_SLASH && rhs == 0) begin
            first_err = ST_DIV0;
          end else begin
            case (c)
              CH_PLUS:  res = lhs + rhs;
              CH_MINUS: res = lhs - rhs;
              CH_STAR:  res = lhs * rhs;
              default:  res = quotient_toward_zero(lhs, rhs);
            endcase
            live_count--;
            stack_mem[live_count - 1] = res;
          end
        end
      end
    end
  endfunction

  // End of expression: queue the one result it produces, then clear state.
  function automatic void close_expression();
    outcome_t o;
    o.val = '0;
    if (bad_seen || !any_seen) begin
      o.st = ST_BAD;
    end else if (first_err != ST_OK) begin
      o.st = first_err;
    end else if (live_count != 1) begin
      o.st = ST_COUNT;
    end else begin
      o.st = ST_OK;
      o.val = stack_mem[0];
    end
    pending_outcomes.push_back(o);
    live_count = 0;
    prev_digit = 1'b0;
    bad_seen = 1'b0;
    any_seen = 1'b0;
    first_err = ST_OK;
  endfunction

  function automatic void flag_error(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 38);
  end

  // Each accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        flag_error($sformatf("unexpected result value %0d status %0d",
                             $signed(value), status));
      end else begin
        want = pending_outcomes.pop_front();
        if (value !== want.val)
          flag_error($sformatf("value expected %0d (%h) got %0d (%h)",
                               $signed(want.val), want.val, $signed(value), value));
        if (status !== want.st)
          flag_error($sformatf("status expected %0d got %0d", want.st, status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Present one request and hold it until accepted. Valid is not dropped after
  // acceptance here; the next call either re-drives it or idles first.
  task automatic send_item(input logic [7:0] c, input logic nc, input logic lst);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    no_char   <= nc;
    last      <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!nc) evaluate_char(c);
    if (lst) close_expression();
  endtask

  // Send a string one character per request; last rides on the final one.
  task automatic send_text(input string s, input bit close = 1'b1);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0, close && (i == s.len() - 1));
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic wait_drained(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Build a well-formed expression with random content, damage it as asked,
  // sprinkle in no_char requests and send it.
  task automatic random_expression(input flaw_t flaw);
    sym_t       syms[$];
    int         joins[$];
    logic [7:0] ch;
    int         n_operands, pushed, live, pos;
    bit         deep, close_blank;
    n_operands = ($urandom_range(11) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
    deep = n_operands >= 30;  // push everything first to reach the depth limit
    pushed = 0;
    live = 0;
    while (pushed < n_operands || live > 1) begin
      if (pushed < n_operands && (live < 2 || deep || $urandom_range(1) == 1)) begin
        ch = CH_ZERO + 8'($urandom_range(9));
        syms.push_back({ch, 1'b0});
        syms.push_back({CH_SPACE, 1'b0});
        if ($urandom_range(5) == 0) syms.push_back({CH_SPACE, 1'b0});
        pushed++;
        live++;
      end else begin
        syms.push_back({pick_operator(), 1'b0});
        if ($urandom_range(1)) syms.push_back({CH_SPACE, 1'b0});
        live--;
      end
    end

    case (flaw)
      FLAW_JOINED: begin
        for (int i = 0; i + 1 < syms.size(); i++)
          if (syms[i].c >= CH_ZERO && syms[i].c <= CH_NINE && syms[i + 1].c == CH_SPACE)
            joins.push_back(i + 1);
        if (joins.size() > 0) syms.delete(joins[$urandom_range(joins.size() - 1)]);
      end
      FLAW_UNDERFLOW: syms.insert(0, {pick_operator(), 1'b0});
      FLAW_LEFTOVER: begin
        syms.insert(0, {CH_SPACE, 1'b0});
        syms.insert(0, {CH_ZERO + 8'($urandom_range(9)), 1'b0});
      end
      FLAW_NOISE: syms.insert($urandom_range(syms.size() - 1), {random_byte(), 1'b0});
      FLAW_JUNK: begin
        syms.delete();
        repeat ($urandom_range(6)) syms.push_back({random_byte(), 1'b0});
      end
      default: ;
    endcase

    // no_char requests in the middle carry a random code that must be ignored
    if (syms.size() > 0 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(syms.size() - 1);
        syms.insert(pos, {random_byte(), 1'b1});
      end
    end

    close_blank = (syms.size() == 0) || ($urandom_range(9) == 0);
    for (int i = 0; i < syms.size(); i++)
      send_item(syms[i].c, syms[i].blank, !close_blank && (i == syms.size() - 1));
    if (close_blank) send_item(random_byte(), 1'b1, 1'b1);
  endtask

  task automatic random_batch(input int n_items);
    int    stop_at, roll;
    flaw_t flaw;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      flaw = (roll < 70) ? FLAW_NONE : flaw_t'(1 + roll % 5);
      random_expression(flaw);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All four operators, negative results, wrap at 32 bits, truncation toward zero.
  task automatic test_arithmetic();
    send_text("1 2 +");
    send_text("0 9 -");
    send_text("9 9 * 9 *");
    send_text("0 7 - 2 /");
    send_text("7 0 2 - /");
    send_text("0 7 - 0 2 - /");
    // 8^10 * 2 = 2^31 wraps to the most negative value; minus one gives the most positive
    send_text("8 8 * 8 * 8 * 8 * 8 * 8 * 8 * 8 * 8 * 2 *");
    send_text("8 8 * 8 * 8 * 8 * 8 * 8 * 8 * 8 * 8 * 2 * 1 -");
    // most negative over minus one stays most negative
    send_text("8 8 * 8 * 8 * 8 * 8 * 8 * 8 * 8 * 8 * 2 * 0 1 - /");
    wait_drained(0);
  endtask

  task automatic test_eval_errors();
    send_text("5 0 /");
    send_text("+");
    send_text("1 + 5 0 /");    // first error is kept
    send_text("5 0 / +");
    send_text("1 2 + 3");      // final count of two
    send_text("1 2 + x");      // bad input outranks the count error
    send_text("1 + x");        // bad input outranks too few operands
    wait_drained(0);
  endtask

  task automatic test_bad_input();
    send_text("12 +");         // digit not followed by a space
    send_text("1+");
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);       // empty expression
    // no_char between digits leaves the digit flag set
    send_text("1", 1'b0);
    send_item(8'h78, 1'b1, 1'b0);
    send_text("2");
    // no_char with a junk code inside a valid expression, then closing one
    send_text("3 ", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("4 + ", 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);
    wait_drained(0);
  endtask

  task automatic test_overflow();
    string s;
    s = "";
    for (int i = 0; i < STACK_DEPTH; i++) s = {s, "1 "};
    for (int i = 1; i < STACK_DEPTH; i++) s = {s, "+ "};
    send_text(s);                          // full depth, sums to 32
    s = "";
    for (int i = 0; i <= STACK_DEPTH; i++) s = {s, "9 "};
    send_text({s, "+"});                   // one push too many
    wait_drained(0);
  endtask

  task automatic test_random_mix();
    random_batch(320);
  endtask

  // The sender holds off until every result is back, several times over.
  task automatic test_drain_pause();
    repeat (4) begin
      random_expression(FLAW_NONE);
      random_expression(FLAW_NONE);
      wait_drained(0);
    end
  endtask

  // Long stretch with both sides always ready.
  task automatic test_back_to_back();
    steady = 1'b1;
    random_batch(200);
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_arithmetic();
    test_eval_errors();
    test_bad_input();
    test_overflow();
    test_random_mix();
    test_drain_pause();
    test_back_to_back();
    wait_drained(SETTLE_CYCLES);
    foreach (pending_outcomes[i])
      flag_error($sformatf("result never arrived: value %0d status %0d",
                           $signed(pending_outcomes[i].val), pending_outcomes[i].st));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
